### rtl/fdt_pkg.sv
// Shared types and constants for the frame deadline tracker.
// Used by frame_deadline_tracker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package fdt_pkg;

  // Field widths
  localparam int FID_W   = 32;
  localparam int CNT16_W = 16;
  localparam int TIME_W  = 32;

  // Defaults for top-level parameters and registers
  localparam int            TABLE_DEPTH_DEF = 64;
  localparam logic [15:0]   DEADLINE_RESET  = 16'd33;

  // Configuration register map
  localparam int            PADDR_W       = 2;
  localparam logic [PADDR_W-1:0] ADDR_DEADLINE = 2'd0;

  // Input beat
  typedef struct packed {
    logic [FID_W-1:0]   frame_id;
    logic [CNT16_W-1:0] fragment_total;
    logic [TIME_W-1:0]  send_time_ms;
    logic [TIME_W-1:0]  arrival_time_ms;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic               frame_complete;
    logic               on_time;
    logic [TIME_W-1:0]  delay_ms;
    logic [31:0]        frames_seen;
    logic [31:0]        frames_on_time;
    logic [31:0]        frames_late;
    logic [31:0]        frames_incomplete;
  } out_item_t;

  // One frame table slot
  typedef struct packed {
    logic               valid;
    logic [FID_W-1:0]   tag;
    logic [CNT16_W-1:0] fragment_total;
    logic [CNT16_W-1:0] arrived;
    logic [TIME_W-1:0]  send_time;
    logic               done;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_CLR  = 7'b000_0001,
    ST_IDLE = 7'b000_0010,
    ST_RD   = 7'b000_0100,
    ST_CHK  = 7'b000_1000,
    ST_DLY  = 7'b001_0000,
    ST_CMP  = 7'b010_0000,
    ST_WR   = 7'b100_0000
  } state_t;

endpackage

`default_nettype wire

### rtl/frame_deadline_tracker.sv
// Top level of the frame deadline tracker: sequencer, shared subtractor,
// counters and APB register. Depends on fdt_pkg and fdt_ram.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                   Handshake
// input     start, busy, in_item                    beat taken when start && !busy
// result    out_valid, out_item                     one-cycle strobe, no back-pressure
// config    psel penable pwrite paddr pwdata        write at psel&penable&pwrite&pready
//           prdata pready                           pready tied high
//
// An item passes through table read, check, (delay and deadline compare, only
// when it completes its frame) and write-back before the next item is accepted;
// delay and compare share one 33-bit subtractor. The slot index is the low bits
// of frame_id (TABLE_DEPTH is a power of two). The result strobe is registered
// and comes in the cycle after the write-back. After reset a clearing pass
// zeroes every table slot; busy is high until it ends. The receiver cannot stall results.

module frame_deadline_tracker #(
  parameter int TABLE_DEPTH = fdt_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input channel
  input  wire logic                         start,
  output      logic                         busy,
  input  wire fdt_pkg::in_item_t            in_item,
  // result channel
  output      logic                         out_valid,
  output      fdt_pkg::out_item_t           out_item,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fdt_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output      logic [31:0]                  prdata,
  output      logic                         pready
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // State and registers
  fdt_pkg::state_t            state_r, state_nxt;
  fdt_pkg::in_item_t          in_r, in_nxt;
  fdt_pkg::entry_t            ent_r, ent_nxt;
  fdt_pkg::out_item_t         out_r, out_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]           rem_r, rem_nxt;
  logic [IDX_W-1:0]           clr_r, clr_nxt;
  logic                       cand_r, cand_nxt;
  logic                       ontime_r, ontime_nxt;
  logic [31:0]                delay_r, delay_nxt;
  logic [31:0]                seen_r, seen_nxt;
  logic [31:0]                on_cnt_r, on_cnt_nxt;
  logic [31:0]                late_r, late_nxt;
  logic [31:0]                inc_r, inc_nxt;
  logic [15:0]                deadline_r;

  // RAM hookup
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  fdt_pkg::entry_t            ram_wdata;
  logic                       ram_re;
  fdt_pkg::entry_t            ram_rdata;

  // Shared subtractor
  logic [31:0]                sub_a, sub_b;
  logic [32:0]                sub_diff;
  logic                       sub_borrow;

  // Check-stage helpers
  fdt_pkg::entry_t            old_ent, new_ent;
  logic                       hit;

  fdt_ram #(
    .WIDTH (fdt_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rem_r),
    .rdata (ram_rdata)
  );

  // Operand select for the one subtractor
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state_r)
      fdt_pkg::ST_DLY: begin
        sub_a = in_r.arrival_time_ms;
        sub_b = ent_r.send_time;
      end
      fdt_pkg::ST_CMP: begin
        sub_a = {16'b0, deadline_r};
        sub_b = delay_r;
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[32];

  // Slot lookup and update on the read data
  assign old_ent = ram_rdata;
  assign hit     = old_ent.valid && (old_ent.tag == in_r.frame_id);

  always_comb begin
    new_ent = old_ent;
    if (!hit) begin
      new_ent.valid          = 1'b1;
      new_ent.tag            = in_r.frame_id;
      new_ent.fragment_total = in_r.fragment_total;
      new_ent.send_time      = in_r.send_time_ms;
      new_ent.arrived        = 16'd1;
      new_ent.done           = 1'b0;
    end else begin
      new_ent.arrived = old_ent.arrived + 16'd1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    ent_nxt       = ent_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    rem_nxt       = rem_r;
    clr_nxt       = clr_r;
    cand_nxt      = cand_r;
    ontime_nxt    = ontime_r;
    delay_nxt     = delay_r;
    seen_nxt      = seen_r;
    on_cnt_nxt    = on_cnt_r;
    late_nxt      = late_r;
    inc_nxt       = inc_r;
    ram_we        = 1'b0;
    ram_waddr     = rem_r;
    ram_wdata     = ent_r;
    ram_re        = 1'b0;
    case (state_r)
      fdt_pkg::ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = fdt_pkg::ST_IDLE;
        end
      end
      fdt_pkg::ST_IDLE: begin
        if (start) begin
          // slot index: frame_id modulo the power-of-two depth
          in_nxt    = in_item;
          rem_nxt   = in_item.frame_id[IDX_W-1:0];
          state_nxt = fdt_pkg::ST_RD;
        end
      end
      fdt_pkg::ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = fdt_pkg::ST_CHK;
      end
      fdt_pkg::ST_CHK: begin
        ent_nxt    = new_ent;
        cand_nxt   = !new_ent.done && (new_ent.arrived == new_ent.fragment_total);
        ontime_nxt = 1'b0;
        delay_nxt  = '0;
        if (!hit) begin
          seen_nxt = seen_r + 32'd1;
        end
        if (old_ent.valid && !hit && !old_ent.done) begin
          inc_nxt = inc_r + 32'd1;
        end
        state_nxt = cand_nxt ? fdt_pkg::ST_DLY : fdt_pkg::ST_WR;
      end
      fdt_pkg::ST_DLY: begin
        delay_nxt = sub_diff[31:0];
        state_nxt = fdt_pkg::ST_CMP;
      end
      fdt_pkg::ST_CMP: begin
        // no borrow means delay <= deadline
        ontime_nxt   = !sub_borrow;
        ent_nxt.done = 1'b1;
        if (!sub_borrow) begin
          on_cnt_nxt = on_cnt_r + 32'd1;
        end else begin
          late_nxt = late_r + 32'd1;
        end
        state_nxt = fdt_pkg::ST_WR;
      end
      fdt_pkg::ST_WR: begin
        ram_we                    = 1'b1;
        out_valid_nxt             = 1'b1;
        out_nxt.frame_complete    = cand_r;
        out_nxt.on_time           = cand_r && ontime_r;
        out_nxt.delay_ms          = cand_r ? delay_r : 32'd0;
        out_nxt.frames_seen       = seen_r;
        out_nxt.frames_on_time    = on_cnt_r;
        out_nxt.frames_late       = late_r;
        out_nxt.frames_incomplete = inc_r;
        state_nxt                 = fdt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fdt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fdt_pkg::ST_CLR;
      out_valid_r <= 1'b0;
      clr_r       <= '0;
      seen_r      <= '0;
      on_cnt_r    <= '0;
      late_r      <= '0;
      inc_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r       <= clr_nxt;
      seen_r      <= seen_nxt;
      on_cnt_r    <= on_cnt_nxt;
      late_r      <= late_nxt;
      inc_r       <= inc_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    in_r     <= in_nxt;
    ent_r    <= ent_nxt;
    out_r    <= out_nxt;
    rem_r    <= rem_nxt;
    cand_r   <= cand_nxt;
    ontime_r <= ontime_nxt;
    delay_r  <= delay_nxt;
  end

  // Deadline register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadline_r <= fdt_pkg::DEADLINE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == fdt_pkg::ADDR_DEADLINE)) begin
      deadline_r <= pwdata[15:0];
    end
  end

  assign prdata    = (paddr == fdt_pkg::ADDR_DEADLINE) ? {16'b0, deadline_r} : 32'd0;
  assign pready    = 1'b1;
  assign busy      = (state_r != fdt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted beat");

  a_wr_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fdt_pkg::ST_WR) |=> out_valid)
    else $error("write-back not followed by result strobe");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.frame_complete |-> !out_item.on_time && (out_item.delay_ms == 32'd0))
    else $error("on_time or delay set without completion");

endmodule

`default_nettype wire

### rtl/fdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the frame table for frame_deadline_tracker.
`timescale 1ns / 1ps
`default_nettype none

module fdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
